### rtl/core/bfns_pkg.sv
`timescale 1ns / 1ps

package bfns_pkg;

   // fixed field widths
   localparam int CMD_W    = 3;
   localparam int IDX_W    = 13;
   localparam int CFG_W    = 13;
   localparam int FIDX_W   = 12;
   localparam int GROUP_W  = 8;
   localparam int GRPOFF_W = 3;

   // store geometry; the word width is a power of two
   localparam int MAX_BITS  = 4096;
   localparam int WORD_BITS = 64;
   localparam int OFF_W     = $clog2(WORD_BITS);

   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 3'd0,
      CMD_FILL  = 3'd1,
      CMD_SET   = 3'd2,
      CMD_UNSET = 3'd3,
      CMD_GET   = 3'd4,
      CMD_FIND  = 3'd5
   } cmd_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_SWEEP,
      ST_DIV,
      ST_LOAD,
      ST_RMW,
      ST_SCAN,
      ST_PICK,
      ST_FIN,
      ST_RESP
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic div_start;
      logic clear_word;
      logic sweep_start;
      logic sweep_step;
      logic load_start;
      logic scan_step;
      logic enc_group;
      logic enc_pick;
      logic finish_find;
      logic rmw;
      logic res_zero;
      logic res_err;
      logic rsp_load;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      cmd_type cmd;
      logic    in_range;
      logic    init_last;
      logic    at_limit;
      logic    scan_hit;
   } stat_type;

endpackage

### rtl/core/bitmap_with_find_next_set.sv
`timescale 1ns / 1ps

// channel   dir  data                          sideband
// req_      in   tdata: bit_index[12:0]        tuser: command[2:0]
// rsp_      out  tdata: bit_value, found_index tuser: found, index_error
// csr_      in   wr_data: bits_in_use[12:0]    wr_en strobe, no read-back
//
// one command at a time; W = words in use
// clear/fill: W words, one written per cycle; set/unset/get: split, read, update
// find: words examined from the start word until a set bit or the limit
// out-of-range index, search from past the limit or an unused code: answered from decode
// after reset a clearing pass over all MAX_BITS / WORD_BITS words zeroes the store
// a new request is taken while the previous response waits in its register
module bitmap_with_find_next_set (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // bit_index[12:0], zero pad
   input  logic [2:0]  req_tuser,    // command[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // bit_value[0], found_index[12:1], zero pad
   output logic [1:0]  rsp_tuser,    // found[0], index_error[1]
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data   // bits_in_use
);

   bfns_pkg::ctl_type  ctl;
   bfns_pkg::stat_type stat;

   logic                        bit_value;
   logic                        found;
   logic [bfns_pkg::FIDX_W-1:0] found_index;
   logic                        index_error;

   bfns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .ctl        (ctl)
   );

   bfns_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .stat            (stat),
      .req_command     (req_tuser),
      .req_bit_index   (req_tdata[bfns_pkg::IDX_W-1:0]),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_bit_value   (bit_value),
      .rsp_found       (found),
      .rsp_found_index (found_index),
      .rsp_index_error (index_error)
   );

   // response packing
   assign rsp_tdata = {3'b000, found_index, bit_value};
   assign rsp_tuser = {index_error, found};

endmodule

### rtl/core/bfns_div.sv
`timescale 1ns / 1ps

// split of a bit index into word index and bit offset, registered on start
module bfns_div (
   input  logic                          clock,
   input  logic                          start,
   input  logic [bfns_pkg::IDX_W-1:0]    dividend,
   output logic [bfns_pkg::IDX_W-1:0]    quotient,
   output logic [bfns_pkg::OFF_W-1:0]    remainder
);

   logic [bfns_pkg::IDX_W-1:0] quo_ff;
   logic [bfns_pkg::OFF_W-1:0] rem_ff;

   // word index from the upper bits, offset from the lower bits
   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend >> bfns_pkg::OFF_W;
         rem_ff <= dividend[bfns_pkg::OFF_W-1:0];
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

### rtl/core/bfns_dp.sv
`timescale 1ns / 1ps

// word store, limit register, scan counters, bit encoder and result registers
module bfns_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bfns_pkg::ctl_type             ctl,
   output bfns_pkg::stat_type            stat,
   input  logic [bfns_pkg::CMD_W-1:0]    req_command,
   input  logic [bfns_pkg::IDX_W-1:0]    req_bit_index,
   input  logic                          csr_wr_en,
   input  logic [bfns_pkg::CFG_W-1:0]    csr_wr_data,
   output logic                          rsp_bit_value,
   output logic                          rsp_found,
   output logic [bfns_pkg::FIDX_W-1:0]   rsp_found_index,
   output logic                          rsp_index_error
);

   localparam int MAX_BITS   = bfns_pkg::MAX_BITS;
   localparam int WORD_BITS  = bfns_pkg::WORD_BITS;
   localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WIDX       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int RW         = bfns_pkg::OFF_W;
   localparam int CW_RAW     = $clog2(MAX_BITS + WORD_BITS + 1);
   localparam int CW         = (CW_RAW > bfns_pkg::IDX_W) ? CW_RAW : bfns_pkg::IDX_W;
   localparam int NG         = (WORD_BITS + bfns_pkg::GROUP_W - 1) / bfns_pkg::GROUP_W;
   localparam int PW         = NG * bfns_pkg::GROUP_W;

   localparam logic [WIDX-1:0] LAST_WORD = WIDX'(WORD_COUNT - 1);
   localparam logic [CW-1:0]   MAX_LIM   = CW'(MAX_BITS);
   localparam logic [CW-1:0]   WORD_STEP = CW'(WORD_BITS);

   // word store
   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 rd_en, wr_en;
   logic [WIDX-1:0]      raddr;
   logic [WORD_BITS-1:0] wdata;

   logic [bfns_pkg::CFG_W-1:0] biu_ff;
   bfns_pkg::cmd_type          cmd_ff;
   logic [bfns_pkg::IDX_W-1:0] idx_ff;
   logic [WIDX-1:0]            w_ff, w_in;
   logic [CW-1:0]              base_ff, base_in;
   logic                       first_ff, first_in;

   logic [CW-1:0]              lim;
   logic [CW-1:0]              biu_ext;
   logic [bfns_pkg::IDX_W-1:0] quo;
   logic [RW-1:0]              rem;
   logic [WORD_BITS-1:0]       bit_sel;
   logic [WORD_BITS-1:0]       masked;
   logic [PW-1:0]              padded;

   logic                        grp_nz_ff [NG];
   logic [bfns_pkg::GRPOFF_W-1:0] grp_off_ff [NG];
   logic                        grp_nz_in [NG];
   logic [bfns_pkg::GRPOFF_W-1:0] grp_off_in [NG];
   logic [RW-1:0]               b_ff, b_in;
   logic [CW-1:0]               pos;

   logic                        res_bit_ff, res_found_ff, res_err_ff;
   logic [bfns_pkg::FIDX_W-1:0] res_fidx_ff;
   logic                        out_bit_ff, out_found_ff, out_err_ff;
   logic [bfns_pkg::FIDX_W-1:0] out_fidx_ff;

   bfns_div u_div (
      .clock     (clock),
      .start     (ctl.div_start),
      .dividend  (idx_ff),
      .quotient  (quo),
      .remainder (rem)
   );

   // limit saturated to the store size
   always_comb begin
      biu_ext = CW'(biu_ff);
      lim     = (biu_ext > MAX_LIM) ? MAX_LIM : biu_ext;
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         biu_ff <= bfns_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         biu_ff <= csr_wr_data;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         cmd_ff <= bfns_pkg::cmd_type'(req_command);
         idx_ff <= req_bit_index;
      end
   end

   // word pointer, word base position and first-word flag
   always_comb begin
      w_in     = w_ff;
      base_in  = base_ff;
      first_in = first_ff;
      if (ctl.sweep_start) begin
         w_in    = '0;
         base_in = '0;
      end else if (ctl.clear_word) begin
         w_in = w_ff + 1'b1;
      end else if (ctl.sweep_step || ctl.scan_step) begin
         w_in     = w_ff + 1'b1;
         base_in  = base_ff + WORD_STEP;
         first_in = 1'b0;
      end else if (ctl.load_start) begin
         w_in     = quo[WIDX-1:0];
         base_in  = CW'(idx_ff) - CW'(rem);
         first_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= '0;
      end else begin
         w_ff <= w_in;
      end
      base_ff  <= base_in;
      first_ff <= first_in;
   end

   // store port selection
   always_comb begin
      bit_sel = WORD_BITS'(1) << rem;
      rd_en   = ctl.load_start || ctl.scan_step;
      raddr   = ctl.load_start ? quo[WIDX-1:0] : (w_ff + 1'b1);
      wr_en   = 1'b0;
      wdata   = '0;
      if (ctl.clear_word) begin
         wr_en = 1'b1;
      end else if (ctl.sweep_step) begin
         wr_en = 1'b1;
         wdata = (cmd_ff == bfns_pkg::CMD_FILL) ? '1 : '0;
      end else if (ctl.rmw && cmd_ff == bfns_pkg::CMD_SET) begin
         wr_en = 1'b1;
         wdata = rdata_ff | bit_sel;
      end else if (ctl.rmw && cmd_ff == bfns_pkg::CMD_UNSET) begin
         wr_en = 1'b1;
         wdata = rdata_ff & ~bit_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[w_ff] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

   // per-group lowest set bit of the masked word
   always_comb begin
      masked = first_ff ? (rdata_ff & ({WORD_BITS{1'b1}} << rem)) : rdata_ff;
      padded = PW'(masked);
      for (int g = 0; g < NG; g++) begin
         grp_nz_in[g]  = |padded[g*bfns_pkg::GROUP_W +: bfns_pkg::GROUP_W];
         grp_off_in[g] = '0;
         for (int k = bfns_pkg::GROUP_W - 1; k >= 0; k--) begin
            if (padded[g*bfns_pkg::GROUP_W + k]) begin
               grp_off_in[g] = bfns_pkg::GRPOFF_W'(k);
            end
         end
      end
   end

   // lowest non-empty group
   always_comb begin
      b_in = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_nz_ff[g]) begin
            b_in = RW'(g * bfns_pkg::GROUP_W + int'(grp_off_ff[g]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enc_group) begin
         for (int g = 0; g < NG; g++) begin
            grp_nz_ff[g]  <= grp_nz_in[g];
            grp_off_ff[g] <= grp_off_in[g];
         end
      end
      if (ctl.enc_pick) begin
         b_ff <= b_in;
      end
   end

   assign pos = base_ff + CW'(b_ff);

   // result of the current command
   always_ff @(posedge clock) begin
      if (ctl.res_zero) begin
         res_bit_ff   <= 1'b0;
         res_found_ff <= 1'b0;
         res_fidx_ff  <= '0;
         res_err_ff   <= 1'b0;
      end else if (ctl.res_err) begin
         res_bit_ff   <= 1'b0;
         res_found_ff <= 1'b0;
         res_fidx_ff  <= '0;
         res_err_ff   <= 1'b1;
      end else if (ctl.rmw) begin
         res_bit_ff   <= (cmd_ff == bfns_pkg::CMD_GET) ? rdata_ff[rem] : 1'b0;
         res_found_ff <= 1'b0;
         res_fidx_ff  <= '0;
         res_err_ff   <= 1'b0;
      end else if (ctl.finish_find) begin
         res_bit_ff   <= 1'b0;
         res_found_ff <= (pos < lim);
         res_fidx_ff  <= (pos < lim) ? pos[bfns_pkg::FIDX_W-1:0] : '0;
         res_err_ff   <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (ctl.rsp_load) begin
         out_bit_ff   <= res_bit_ff;
         out_found_ff <= res_found_ff;
         out_fidx_ff  <= res_fidx_ff;
         out_err_ff   <= res_err_ff;
      end
   end

   assign rsp_bit_value   = out_bit_ff;
   assign rsp_found       = out_found_ff;
   assign rsp_found_index = out_fidx_ff;
   assign rsp_index_error = out_err_ff;

   // status
   always_comb begin
      stat.cmd       = cmd_ff;
      stat.in_range  = CW'(idx_ff) < lim;
      stat.init_last = (w_ff == LAST_WORD);
      stat.at_limit  = (base_ff >= lim);
      stat.scan_hit  = |masked;
   end

endmodule

### rtl/core/bfns_ctrl.sv
`timescale 1ns / 1ps

// command sequencer and response handshake
module bfns_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  bfns_pkg::stat_type stat,
   output bfns_pkg::ctl_type  ctl
);

   bfns_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bfns_pkg::ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      case (state_ff)
         bfns_pkg::ST_INIT: begin
            ctl.clear_word = 1'b1;
            if (stat.init_last) begin
               state_in = bfns_pkg::ST_IDLE;
            end
         end
         bfns_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.accept = 1'b1;
               state_in   = bfns_pkg::ST_DECODE;
            end
         end
         bfns_pkg::ST_DECODE: begin
            case (stat.cmd)
               bfns_pkg::CMD_CLEAR, bfns_pkg::CMD_FILL: begin
                  ctl.sweep_start = 1'b1;
                  state_in        = bfns_pkg::ST_SWEEP;
               end
               bfns_pkg::CMD_SET, bfns_pkg::CMD_UNSET, bfns_pkg::CMD_GET: begin
                  if (stat.in_range) begin
                     ctl.div_start = 1'b1;
                     state_in      = bfns_pkg::ST_DIV;
                  end else begin
                     ctl.res_err = 1'b1;
                     state_in    = bfns_pkg::ST_RESP;
                  end
               end
               bfns_pkg::CMD_FIND: begin
                  if (stat.in_range) begin
                     ctl.div_start = 1'b1;
                     state_in      = bfns_pkg::ST_DIV;
                  end else begin
                     ctl.res_zero = 1'b1;
                     state_in     = bfns_pkg::ST_RESP;
                  end
               end
               default: begin
                  ctl.res_zero = 1'b1;
                  state_in     = bfns_pkg::ST_RESP;
               end
            endcase
         end
         bfns_pkg::ST_SWEEP: begin
            if (stat.at_limit) begin
               ctl.res_zero = 1'b1;
               state_in     = bfns_pkg::ST_RESP;
            end else begin
               ctl.sweep_step = 1'b1;
            end
         end
         bfns_pkg::ST_DIV: begin
            ctl.load_start = 1'b1;
            state_in       = bfns_pkg::ST_LOAD;
         end
         bfns_pkg::ST_LOAD: begin
            state_in = (stat.cmd == bfns_pkg::CMD_FIND) ? bfns_pkg::ST_SCAN
                                                       : bfns_pkg::ST_RMW;
         end
         bfns_pkg::ST_RMW: begin
            ctl.rmw  = 1'b1;
            state_in = bfns_pkg::ST_RESP;
         end
         bfns_pkg::ST_SCAN: begin
            if (stat.at_limit) begin
               ctl.res_zero = 1'b1;
               state_in     = bfns_pkg::ST_RESP;
            end else if (stat.scan_hit) begin
               ctl.enc_group = 1'b1;
               state_in      = bfns_pkg::ST_PICK;
            end else begin
               ctl.scan_step = 1'b1;
            end
         end
         bfns_pkg::ST_PICK: begin
            ctl.enc_pick = 1'b1;
            state_in     = bfns_pkg::ST_FIN;
         end
         bfns_pkg::ST_FIN: begin
            ctl.finish_find = 1'b1;
            state_in        = bfns_pkg::ST_RESP;
         end
         bfns_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               ctl.rsp_load = 1'b1;
               state_in     = bfns_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfns_pkg::ST_IDLE;
         end
      endcase
   end

   // output slot
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

### bench/bfns_checker.sv
`timescale 1ns / 1ps

module bfns_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,    // bit_index[12:0], zero pad
   input  logic [2:0]  req_tuser,    // command[2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,    // bit_value[0], found_index[12:1], zero pad
   input  logic [1:0]  rsp_tuser,    // found[0], index_error[1]
   input  logic        csr_wr_en,
   input  logic [12:0] csr_wr_data,
   output int          fail_count,
   output int          outstanding,
   output int          results_checked,
   output int          finds_hit,
   output int          index_errors
);

   localparam int MAX_BITS   = bfns_pkg::MAX_BITS;
   localparam int WORD_BITS  = bfns_pkg::WORD_BITS;
   localparam int WORD_COUNT = MAX_BITS / WORD_BITS;

   typedef struct packed {
      logic                          bit_value;
      logic                          found;
      logic [bfns_pkg::FIDX_W-1:0]   found_index;
      logic                          index_error;
   } bit_result_type;

   // shadow copy of the store and the limit register
   logic [WORD_BITS-1:0]       bitmap_words [0:WORD_COUNT-1];
   logic [bfns_pkg::CFG_W-1:0] bits_in_use;

   bit_result_type expected_results [$];
   bit_result_type got;
   bit_result_type want;
   bit_result_type predicted;

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("mismatch at %0t ns: %s", $time, what);
   endtask

   // apply one command to the shadow store and work out its response
   task automatic apply_command(input logic [bfns_pkg::CMD_W-1:0] cmd,
                                input logic [bfns_pkg::IDX_W-1:0] idx,
                                output bit_result_type res);
      int unsigned          lim;
      int unsigned          nw;
      int unsigned          w;
      int unsigned          b;
      int unsigned          pos;
      logic [WORD_BITS-1:0] word;
      res = '0;
      lim = (bits_in_use > MAX_BITS) ? MAX_BITS : bits_in_use;
      nw  = (lim + WORD_BITS - 1) / WORD_BITS;
      case (cmd)
         bfns_pkg::CMD_CLEAR, bfns_pkg::CMD_FILL: begin
            for (w = 0; w < nw; w++)
               bitmap_words[w] = (cmd == bfns_pkg::CMD_FILL) ? '1 : '0;
         end
         bfns_pkg::CMD_SET, bfns_pkg::CMD_UNSET, bfns_pkg::CMD_GET: begin
            if (idx >= lim) begin
               res.index_error = 1'b1;
            end else begin
               w = idx / WORD_BITS;
               b = idx % WORD_BITS;
               if (cmd == bfns_pkg::CMD_SET)
                  bitmap_words[w][b] = 1'b1;
               else if (cmd == bfns_pkg::CMD_UNSET)
                  bitmap_words[w][b] = 1'b0;
               else
                  res.bit_value = bitmap_words[w][b];
            end
         end
         bfns_pkg::CMD_FIND: begin
            if (idx < lim) begin
               w = idx / WORD_BITS;
               // mask off positions below the start in the first word
               word = bitmap_words[w] & ~((64'd1 << (idx % WORD_BITS)) - 64'd1);
               while (word == '0 && w + 1 < nw) begin
                  w++;
                  word = bitmap_words[w];
               end
               if (word != '0) begin
                  b = 0;
                  while (!word[b])
                     b++;
                  pos = w * WORD_BITS + b;
                  // ones beyond the limit left by a fill do not count
                  if (pos < lim) begin
                     res.found       = 1'b1;
                     res.found_index = pos[bfns_pkg::FIDX_W-1:0];
                  end
               end
            end
         end
         default: ;
      endcase
   endtask

   // watch both channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WORD_COUNT; i++)
            bitmap_words[i] = '0;
         bits_in_use = bfns_pkg::CFG_RESET;
         expected_results.delete();
         fail_count      = 0;
         outstanding     = 0;
         results_checked = 0;
         finds_hit       = 0;
         index_errors    = 0;
      end else begin
         // compare a response transaction with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.bit_value   = rsp_tdata[0];
            got.found_index = rsp_tdata[12:1];
            got.found       = rsp_tuser[0];
            got.index_error = rsp_tuser[1];
            if (expected_results.size() == 0) begin
               report_mismatch("response with no command waiting");
            end else begin
               want = expected_results.pop_front();
               results_checked++;
               if (got.bit_value !== want.bit_value)
                  report_mismatch($sformatf("bit_value got %0d, expected %0d",
                                            got.bit_value, want.bit_value));
               if (got.found !== want.found)
                  report_mismatch($sformatf("found got %0d, expected %0d",
                                            got.found, want.found));
               if (got.found_index !== want.found_index)
                  report_mismatch($sformatf("found_index got %0d, expected %0d",
                                            got.found_index, want.found_index));
               if (got.index_error !== want.index_error)
                  report_mismatch($sformatf("index_error got %0d, expected %0d",
                                            got.index_error, want.index_error));
               if (want.found)
                  finds_hit++;
               if (want.index_error)
                  index_errors++;
            end
         end
         // predict for an accepted command transaction
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser, req_tdata[bfns_pkg::IDX_W-1:0], predicted);
            expected_results.push_back(predicted);
         end
         // register write takes effect for later commands
         if (csr_wr_en)
            bits_in_use = csr_wr_data;
         outstanding = expected_results.size();
      end
   end

endmodule

### bench/tb_bitmap_with_find_next_set.sv
`timescale 1ns / 1ps

module tb_bitmap_with_find_next_set;

   localparam logic [bfns_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [bfns_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 100;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // bit_index[12:0], zero pad
   logic [2:0]  req_tuser;    // command[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // bit_value[0], found_index[12:1], zero pad
   logic [1:0]  rsp_tuser;    // found[0], index_error[1]
   logic        csr_wr_en;
   logic [12:0] csr_wr_data;

   int fail_count;
   int outstanding;
   int results_checked;
   int finds_hit;
   int index_errors;

   int unsigned limit_now;
   int          commands_sent;
   int          limit_writes;
   bit          quiet;
   bit          long_hold;

   bitmap_with_find_next_set DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   bfns_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .finds_hit       (finds_hit),
      .index_errors    (index_errors)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run limit
   initial begin
      #10_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // response side: random short stalls, one long hold-off on request
   initial begin
      bit hold_taken;
      hold_taken = 1'b0;
      rsp_tready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // offer one command, with an occasional gap first, and wait for its transaction
   task automatic send_command(input logic [bfns_pkg::CMD_W-1:0] cmd,
                               input logic [bfns_pkg::IDX_W-1:0] idx);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, idx};
      req_tuser  <= cmd;
      do
         @(posedge clock);
      while (!req_tready);
      commands_sent++;
   endtask

   // stop offering and wait until every response is back
   task automatic wait_drained;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   task automatic write_limit(input logic [bfns_pkg::CFG_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      limit_now = value;
      limit_writes++;
   endtask

   // mostly in-range work on the bitmap, some boundary and wild indexes
   task automatic run_random_phase(input int count);
      int unsigned                pick;
      int unsigned                sel;
      int unsigned                span;
      logic [bfns_pkg::CMD_W-1:0] cmd;
      logic [bfns_pkg::IDX_W-1:0] idx;
      span = (limit_now > 4096) ? 4096 : limit_now;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 4)
            cmd = bfns_pkg::CMD_CLEAR;
         else if (pick < 8)
            cmd = bfns_pkg::CMD_FILL;
         else if (pick < 38)
            cmd = bfns_pkg::CMD_SET;
         else if (pick < 53)
            cmd = bfns_pkg::CMD_UNSET;
         else if (pick < 70)
            cmd = bfns_pkg::CMD_GET;
         else if (pick < 97)
            cmd = bfns_pkg::CMD_FIND;
         else
            cmd = pick[0] ? CMD_SPARE_HI : CMD_SPARE_LO;
         sel = $urandom_range(0, 9);
         if (span == 0 || sel == 0)
            idx = 13'($urandom_range(0, 8191));
         else if (sel == 1)
            idx = 13'(span - 1 + $urandom_range(0, 2));
         else
            idx = 13'($urandom_range(0, span - 1));
         send_command(cmd, idx);
      end
   endtask

   // stimulus and verdict
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      quiet         = 1'b0;
      long_hold     = 1'b0;
      commands_sent = 0;
      limit_writes  = 0;
      limit_now     = bfns_pkg::CFG_RESET;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: ends of the index range, every command, past-limit cases
      write_limit(bfns_pkg::CFG_RESET);
      send_command(bfns_pkg::CMD_CLEAR, 13'd0);
      send_command(bfns_pkg::CMD_FIND, 13'd0);
      send_command(bfns_pkg::CMD_GET, 13'd0);
      send_command(bfns_pkg::CMD_SET, 13'd0);
      send_command(bfns_pkg::CMD_SET, 13'd4095);
      send_command(bfns_pkg::CMD_GET, 13'd0);
      send_command(bfns_pkg::CMD_GET, 13'd4095);
      send_command(bfns_pkg::CMD_FIND, 13'd0);
      send_command(bfns_pkg::CMD_FIND, 13'd1);
      send_command(bfns_pkg::CMD_FIND, 13'd4096);
      send_command(bfns_pkg::CMD_SET, 13'd4096);
      send_command(bfns_pkg::CMD_GET, 13'd8191);
      send_command(bfns_pkg::CMD_UNSET, 13'd8191);
      send_command(bfns_pkg::CMD_UNSET, 13'd4095);
      send_command(bfns_pkg::CMD_FIND, 13'd1);
      send_command(bfns_pkg::CMD_SET, 13'd63);
      send_command(bfns_pkg::CMD_SET, 13'd64);
      send_command(bfns_pkg::CMD_FIND, 13'd1);
      send_command(bfns_pkg::CMD_FIND, 13'd64);
      send_command(bfns_pkg::CMD_FILL, 13'd8191);
      send_command(bfns_pkg::CMD_FIND, 13'd4095);
      send_command(bfns_pkg::CMD_UNSET, 13'd0);
      send_command(bfns_pkg::CMD_GET, 13'd0);
      send_command(CMD_SPARE_LO, 13'd8191);
      send_command(CMD_SPARE_HI, 13'd0);

      // random phases over a spread of limits, with one long response hold-off
      run_random_phase(50);
      long_hold = 1'b1;
      run_random_phase(60);
      wait_drained();
      run_random_phase(140);
      write_limit(13'd1);
      run_random_phase(60);
      write_limit(13'd0);
      run_random_phase(40);
      write_limit(13'd64);
      run_random_phase(150);
      write_limit(13'd65);
      run_random_phase(150);
      write_limit(13'h1FFF);
      run_random_phase(200);
      write_limit(13'd100);
      run_random_phase(150);
      write_limit(13'($urandom_range(2, 4094)));
      run_random_phase(150);
      write_limit(13'd4095);
      run_random_phase(100);

      // last phase without any stalls
      quiet = 1'b1;
      write_limit(bfns_pkg::CFG_RESET);
      run_random_phase(150);

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d commands over %0d limit settings %s",
               commands_sent, limit_writes, "(zero, one, word edges, saturated)");
      $display("%0d responses checked, %0d finds located a bit, %0d index errors flagged",
               results_checked, finds_hit, index_errors);
      if (fail_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
